// ===== hdl/fir5d_pkg.sv =====
// ----------------------------------------------------------------------------
// fir5d_pkg
// Shared constants for the five-tap binomial FIR decimator: widths, tap
// weights and register reset values.
// ----------------------------------------------------------------------------
package fir5d_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FACTOR_W         = 10;
  localparam int TAP_COUNT        = 4;
  localparam int GUARD_BITS       = 4;
  localparam int WEIGHT_W         = 3;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

  // weights of the stored taps, newest first; the incoming sample weighs one
  localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [TAP_COUNT] = '{
    WEIGHT_W'(4), WEIGHT_W'(6), WEIGHT_W'(4), WEIGHT_W'(1)
  };

endpackage

// ===== hdl/five_tap_fir_decimator.sv =====
// ----------------------------------------------------------------------------
// five_tap_fir_decimator
// A kept item is registered and shown in the cycle after it is accepted.
// One item per cycle unless the output stalls; the tap sum is combinational.
// Reset: clears delay cells, phase counter and out_valid; factor set to one.
// Binomial 1-4-6-4-1 low-pass over a chain of delay cells, floor divide by
// sixteen, then keep one item in every decimation_factor.
// ----------------------------------------------------------------------------
module five_tap_fir_decimator #(
  parameter int SAMPLE_WIDTH = fir5d_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fir5d_pkg::FACTOR_W-1:0]      decimation_factor,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
  import fir5d_pkg::*;

  localparam int ACC_W = SAMPLE_WIDTH + GUARD_BITS;

  logic                           accept;
  logic                           cfg_write;
  logic [FACTOR_W-1:0]            factor;
  logic [FACTOR_W-1:0]            factor_eff;
  logic [FACTOR_W-1:0]            phase;
  logic [FACTOR_W-1:0]            phase_next;
  logic [FACTOR_W:0]              phase_inc;
  logic                           emit;
  logic signed [SAMPLE_WIDTH-1:0] taps  [TAP_COUNT+1];
  logic signed [ACC_W-1:0]        psums [TAP_COUNT+1];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign taps[0]  = sample_in;
  assign psums[0] = ACC_W'(sample_in);

  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
    fir5d_tap_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .WEIGHT       (TAP_WEIGHT[i])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (accept),
      .tap_in   (taps[i]),
      .tap_out  (taps[i+1]),
      .psum_in  (psums[i]),
      .psum_out (psums[i+1])
    );
  end

  assign factor_eff = (factor == '0) ? FACTOR_W'(1) : factor;
  assign emit       = (phase == '0);
  assign phase_inc  = {1'b0, phase} + (FACTOR_W+1)'(1);
  assign phase_next = (phase_inc >= {1'b0, factor_eff}) ? '0 : phase_inc[FACTOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
      phase  <= '0;
    end else if (cfg_write) begin
      factor <= decimation_factor;
      phase  <= '0;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      sample_out <= psums[TAP_COUNT][ACC_W-1:GUARD_BITS];
    end
  end

endmodule

// ===== hdl/fir5d_tap_cell.sv =====
// ----------------------------------------------------------------------------
// fir5d_tap_cell
// One delay cell of the FIR chain: holds a sample, hands it to the next cell
// on each accepted item, and adds its shift-weighted sample to the partial sum.
// ----------------------------------------------------------------------------
module fir5d_tap_cell #(
  parameter int                                SAMPLE_WIDTH = fir5d_pkg::SAMPLE_WIDTH_DEF,
  parameter logic [fir5d_pkg::WEIGHT_W-1:0]    WEIGHT       = fir5d_pkg::TAP_WEIGHT[0]
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  advance,
  input  logic signed [SAMPLE_WIDTH-1:0]                        tap_in,
  output logic signed [SAMPLE_WIDTH-1:0]                        tap_out,
  input  logic signed [SAMPLE_WIDTH+fir5d_pkg::GUARD_BITS-1:0]  psum_in,
  output logic signed [SAMPLE_WIDTH+fir5d_pkg::GUARD_BITS-1:0]  psum_out
);
  import fir5d_pkg::*;

  localparam int ACC_W = SAMPLE_WIDTH + GUARD_BITS;

  logic signed [SAMPLE_WIDTH-1:0] tap;
  logic signed [ACC_W-1:0]        tap_ext;
  logic signed [ACC_W-1:0]        term4;
  logic signed [ACC_W-1:0]        term2;
  logic signed [ACC_W-1:0]        term1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (advance) begin
      tap <= tap_in;
    end
  end

  assign tap_out = tap;
  assign tap_ext = ACC_W'(tap);
  assign term4   = WEIGHT[2] ? (tap_ext <<< 2) : '0;
  assign term2   = WEIGHT[1] ? (tap_ext <<< 1) : '0;
  assign term1   = WEIGHT[0] ? tap_ext : '0;
  assign psum_out = psum_in + term4 + term2 + term1;

endmodule

// ===== hdl/fir5d_checker.sv =====
// ----------------------------------------------------------------------------
// fir5d_checker
// Port-level checks for the FIR decimator, bound to the top level.
// ----------------------------------------------------------------------------
module fir5d_checker #(
  parameter int SAMPLE_WIDTH = fir5d_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output register");

  a_no_invented_item: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && in_ready) && !out_valid) |=> !out_valid)
    else $error("output item without input item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("stalled output item changed");

endmodule

bind five_tap_fir_decimator fir5d_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fir5d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);
